// ===== hdl/srfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial reply frame checker package
// Shared types, status codes and frame constants.
// ----------------------------------------------------------------------------
package srfc_pkg;

  localparam int unsigned MaxLengthDefault = 245;
  localparam logic [7:0]  CmdResetValue    = 8'h00;

  typedef enum logic [2:0] {
    PH_SYNC,
    PH_HEAD,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_XOR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SYNC     = 3'd1,
    ST_TOO_LONG     = 3'd2,
    ST_TOO_SHORT    = 3'd3,
    ST_XOR_ERR      = 3'd4,
    ST_CMD_MISMATCH = 3'd5,
    ST_DEVICE_ERR   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_data;
    logic        last;
    status_t     status;
    logic [15:0] device_code;
    logic [7:0]  data_count;
  } result_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h0F;
      2'd1:    b = 8'h0F;
      2'd2:    b = 8'hAB;
      default: b = 8'hAB;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/srfc_if.sv =====
// ----------------------------------------------------------------------------
// Serial reply frame checker channels
// Valid/ready channels for received bytes, results and configuration.
// ----------------------------------------------------------------------------
interface srfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       abort;

  modport source (output valid, output rx_byte, output abort, input ready);
  modport sink   (input valid, input rx_byte, input abort, output ready);
endinterface

interface srfc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        is_data;
  logic        last;
  logic [2:0]  status;
  logic [15:0] device_code;
  logic [7:0]  data_count;

  modport source (output valid, output data_byte, output is_data, output last,
                  output status, output device_code, output data_count,
                  input ready);
  modport sink   (input valid, input data_byte, input is_data, input last,
                  input status, input device_code, input data_count,
                  output ready);
endinterface

interface srfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_command;

  modport source (output valid, output expected_command, input ready);
  modport sink   (input valid, input expected_command, output ready);
endinterface

// ===== hdl/serial_reply_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// Serial reply frame checker
// A result is registered with the byte transaction that causes it and is valid in the next cycle.
// Throughput: one byte per cycle unless a held result waits on reply.ready; the result register frees the input side.
// Reset: synchronous; hunts for sync, clears frame state and expected command.
// Checks reply frames byte by byte and streams data bytes and a closing status.
// ----------------------------------------------------------------------------
module serial_reply_frame_checker_unit #(
  parameter int unsigned MAX_LENGTH = srfc_pkg::MaxLengthDefault
) (
  input  logic              clk,
  input  logic              rst,
  srfc_cfg_if.sink          cfg,
  srfc_in_if.sink           rx,
  srfc_out_if.source        reply
);
  import srfc_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_LENGTH + 1);

  logic [7:0]      expected_command;
  phase_t          phase, phase_next;
  logic [LenW-1:0] position, position_next;
  logic [LenW-1:0] frame_length, frame_length_next;
  logic [7:0]      len_hi, len_hi_next;
  logic [7:0]      running_xor, running_xor_next;
  logic            command_matched, command_matched_next;
  logic [15:0]     return_code, return_code_next;

  result_t         res, res_next;
  logic            res_fire;
  logic            out_valid;

  logic            accept;
  logic [7:0]      b;
  logic [15:0]     full_len;
  logic            too_long, too_short;
  logic [LenW:0]   pos_inc;
  logic            last_payload;
  logic            sync_miss;
  logic [LenW+7:0] count_ext;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !out_valid || reply.ready;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  assign full_len     = {len_hi, b};
  assign too_long     = full_len > 16'(MAX_LENGTH);
  assign too_short    = full_len < 16'd3;
  assign pos_inc      = {1'b0, position} + (LenW+1)'(1);
  assign last_payload = pos_inc >= {1'b0, frame_length};
  assign sync_miss    = b != sync_byte(position[1:0]);
  assign count_ext    = {8'd0, frame_length} - (LenW+8)'(3);

  always_comb begin
    phase_next           = phase;
    position_next        = position;
    frame_length_next    = frame_length;
    len_hi_next          = len_hi;
    running_xor_next     = running_xor;
    command_matched_next = command_matched;
    return_code_next     = return_code;
    if (accept) begin
      if (rx.abort) begin
        phase_next           = PH_SYNC;
        position_next        = '0;
        frame_length_next    = '0;
        len_hi_next          = '0;
        running_xor_next     = '0;
        command_matched_next = 1'b0;
        return_code_next     = '0;
      end else begin
        case (phase)
          PH_SYNC: begin
            if (sync_miss) begin
              position_next = '0;
            end else if (position[1:0] == 2'd3) begin
              phase_next       = PH_HEAD;
              position_next    = '0;
              running_xor_next = '0;
            end else begin
              position_next = pos_inc[LenW-1:0];
            end
          end
          PH_HEAD: begin
            running_xor_next = running_xor ^ b;
            if (position[1:0] == 2'd3) begin
              phase_next    = PH_LEN_HI;
              position_next = '0;
            end else begin
              position_next = pos_inc[LenW-1:0];
            end
          end
          PH_LEN_HI: begin
            running_xor_next = running_xor ^ b;
            len_hi_next      = b;
            phase_next       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (too_long || too_short) begin
              phase_next           = PH_SYNC;
              position_next        = '0;
              frame_length_next    = '0;
              len_hi_next          = '0;
              running_xor_next     = '0;
              command_matched_next = 1'b0;
              return_code_next     = '0;
            end else begin
              running_xor_next  = running_xor ^ b;
              frame_length_next = full_len[LenW-1:0];
              phase_next        = PH_PAYLOAD;
              position_next     = '0;
            end
          end
          PH_PAYLOAD: begin
            running_xor_next = running_xor ^ b;
            position_next    = pos_inc[LenW-1:0];
            if (last_payload) begin
              phase_next = PH_XOR;
            end
            if (position == LenW'(0)) begin
              command_matched_next = b == expected_command;
            end else if (position == LenW'(1)) begin
              return_code_next = {b, 8'd0};
            end else if (position == LenW'(2)) begin
              return_code_next = {return_code[15:8], b};
            end
          end
          default: begin
            phase_next           = PH_SYNC;
            position_next        = '0;
            frame_length_next    = '0;
            len_hi_next          = '0;
            running_xor_next     = '0;
            command_matched_next = 1'b0;
            return_code_next     = '0;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_next = '0;
    res_fire = 1'b0;
    if (accept && !rx.abort) begin
      case (phase)
        PH_SYNC: begin
          if (sync_miss) begin
            res_fire        = 1'b1;
            res_next.last   = 1'b1;
            res_next.status = ST_BAD_SYNC;
          end
        end
        PH_LEN_LO: begin
          if (too_long) begin
            res_fire        = 1'b1;
            res_next.last   = 1'b1;
            res_next.status = ST_TOO_LONG;
          end else if (too_short) begin
            res_fire        = 1'b1;
            res_next.last   = 1'b1;
            res_next.status = ST_TOO_SHORT;
          end
        end
        PH_PAYLOAD: begin
          if (position >= LenW'(3)) begin
            res_fire           = 1'b1;
            res_next.is_data   = 1'b1;
            res_next.data_byte = b;
          end
        end
        PH_XOR: begin
          res_fire            = 1'b1;
          res_next.last       = 1'b1;
          res_next.data_count = count_ext[7:0];
          if (b != running_xor) begin
            res_next.status = ST_XOR_ERR;
          end else if (!command_matched) begin
            res_next.status = ST_CMD_MISMATCH;
          end else if (return_code != 16'd0) begin
            res_next.status      = ST_DEVICE_ERR;
            res_next.device_code = return_code;
          end else begin
            res_next.status = ST_OK;
          end
        end
        default: begin
          res_fire = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= CmdResetValue;
      phase            <= PH_SYNC;
      position         <= '0;
      frame_length     <= '0;
      len_hi           <= '0;
      running_xor      <= '0;
      command_matched  <= 1'b0;
      return_code      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        expected_command <= cfg.expected_command;
      end
      phase           <= phase_next;
      position        <= position_next;
      frame_length    <= frame_length_next;
      len_hi          <= len_hi_next;
      running_xor     <= running_xor_next;
      command_matched <= command_matched_next;
      return_code     <= return_code_next;
      if (accept) begin
        out_valid <= res_fire;
      end else if (reply.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_fire) begin
      res <= res_next;
    end
  end

  assign reply.valid       = out_valid;
  assign reply.data_byte   = res.data_byte;
  assign reply.is_data     = res.is_data;
  assign reply.last        = res.last;
  assign reply.status      = res.status;
  assign reply.device_code = res.device_code;
  assign reply.data_count  = res.data_count;

endmodule

// ===== tb/tb_serial_reply_frame_checker_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial reply frame checker testbench
// Sends reply byte streams with random sender gaps and receiver stalls, and
// runs a byte-level frame model beside the block. A small scoreboard queues
// the predicted data and closing status transactions and checks every reply
// transaction against them. The traffic covers good frames, all closing
// error codes, length errors, sync noise, aborts, and a long receiver
// hold-off, across several expected command settings.
// ----------------------------------------------------------------------------
module tb_serial_reply_frame_checker_unit;
  import srfc_pkg::*;

  localparam logic [31:0] SyncWord  = 32'h0F0FABAB;
  localparam int          HoldSpan  = 300;
  localparam int          PhaseSize = 250;

  class frame_tracker;
    logic [7:0]  command;
    phase_t      phase;
    logic [8:0]  pos;
    logic [15:0] flen;
    logic [7:0]  run_xor;
    bit          cmd_ok;
    logic [15:0] ret_code;
    result_t     pending_results[$];
    int          mismatches;
    int          data_seen;
    int          status_seen[8];

    function new();
      command    = CmdResetValue;
      mismatches = 0;
      data_seen  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_SYNC;
      pos      = '0;
      flen     = '0;
      run_xor  = '0;
      cmd_ok   = 1'b0;
      ret_code = '0;
    endfunction

    function void set_command(logic [7:0] c);
      command = c;
    endfunction

    function void push_status(status_t st, logic [15:0] code, logic [7:0] cnt);
      result_t r;
      r             = '0;
      r.last        = 1'b1;
      r.status      = st;
      r.device_code = code;
      r.data_count  = cnt;
      pending_results.push_back(r);
    endfunction

    function void absorb_byte(logic [7:0] b, logic ab);
      result_t     r;
      logic [8:0]  idx;
      logic [15:0] cnt;
      status_t     st;
      if (ab) begin
        restart();
        return;
      end
      case (phase)
        PH_SYNC: begin
          if (b != SyncWord[31 - 8 * pos[1:0] -: 8]) begin
            restart();
            push_status(ST_BAD_SYNC, 16'h0000, 8'h00);
          end else begin
            pos = pos + 9'd1;
            if (pos >= 4) begin
              phase   = PH_HEAD;
              pos     = '0;
              run_xor = '0;
            end
          end
        end
        PH_HEAD: begin
          run_xor ^= b;
          pos = pos + 9'd1;
          if (pos >= 4) begin
            phase = PH_LEN_HI;
            pos   = '0;
          end
        end
        PH_LEN_HI: begin
          run_xor ^= b;
          flen  = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          run_xor ^= b;
          flen[7:0] = b;
          if (flen > MaxLengthDefault) begin
            restart();
            push_status(ST_TOO_LONG, 16'h0000, 8'h00);
          end else if (flen < 3) begin
            restart();
            push_status(ST_TOO_SHORT, 16'h0000, 8'h00);
          end else begin
            phase = PH_PAYLOAD;
            pos   = '0;
          end
        end
        PH_PAYLOAD: begin
          idx = pos;
          run_xor ^= b;
          pos = pos + 9'd1;
          if (pos >= flen) phase = PH_XOR;
          if (idx == 0) begin
            cmd_ok = (b == command);
          end else if (idx == 1) begin
            ret_code = {b, 8'h00};
          end else if (idx == 2) begin
            ret_code[7:0] = b;
          end else begin
            r           = '0;
            r.data_byte = b;
            r.is_data   = 1'b1;
            pending_results.push_back(r);
          end
        end
        PH_XOR: begin
          cnt = flen - 16'd3;
          if (b != run_xor) begin
            push_status(ST_XOR_ERR, 16'h0000, cnt[7:0]);
          end else if (!cmd_ok) begin
            push_status(ST_CMD_MISMATCH, 16'h0000, cnt[7:0]);
          end else if (ret_code != 0) begin
            push_status(ST_DEVICE_ERR, ret_code, cnt[7:0]);
          end else begin
            push_status(ST_OK, 16'h0000, cnt[7:0]);
          end
          restart();
        end
        default: begin
          restart();
        end
      endcase
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: data=%02h is_data=%0b last=%0b st=%0d code=%04h cnt=%0d",
                   got.data_byte, got.is_data, got.last, got.status, got.device_code,
                   got.data_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.is_data) data_seen++;
      else status_seen[got.status]++;
      if (got.data_byte !== want.data_byte || got.is_data !== want.is_data ||
          got.last !== want.last || got.status !== want.status ||
          got.device_code !== want.device_code || got.data_count !== want.data_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected data=%02h is_data=%0b last=%0b st=%0d code=%04h cnt=%0d",
                   want.data_byte, want.is_data, want.last, want.status, want.device_code,
                   want.data_count);
          $display("         actual   data=%02h is_data=%0b last=%0b st=%0d code=%04h cnt=%0d",
                   got.data_byte, got.is_data, got.last, got.status, got.device_code,
                   got.data_count);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  srfc_cfg_if cfg_if ();
  srfc_in_if  rx_if ();
  srfc_out_if reply_if ();

  serial_reply_frame_checker_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_if),
    .rx    (rx_if),
    .reply (reply_if)
  );

  frame_tracker tracker = new();
  bit           idle_on;
  bit           hold_request;
  int           gap_pct;
  int           items_sent;
  int           settings_used;
  logic [7:0]   cur_cmd;

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("[serial_reply_frame_checker_unit] ERROR");
    $finish;
  end

  // reply side: check transactions, then choose ready for the next edge
  initial begin
    int stall_left;
    int hold_left;
    int stall_pct;
    stall_left = 0;
    hold_left  = 0;
    stall_pct  = 20;
    forever begin
      @(posedge clk);
      if (!rst && reply_if.valid && reply_if.ready) begin
        tracker.check_reply('{data_byte:   reply_if.data_byte,
                              is_data:     reply_if.is_data,
                              last:        reply_if.last,
                              status:      status_t'(reply_if.status),
                              device_code: reply_if.device_code,
                              data_count:  reply_if.data_count});
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldSpan;
      end
      if ($urandom_range(0, 63) == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
      if (hold_left > 0) begin
        hold_left--;
        reply_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        reply_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 6) - 1;
        reply_if.ready <= 1'b0;
      end else begin
        reply_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ab);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.abort   <= ab;
    do @(posedge clk); while (!rx_if.ready);
    tracker.absorb_byte(b, ab);
    if (!ab) items_sent++;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd,
                            input logic [15:0] code, input bit bad_xor, input int cut);
    logic [7:0] fb[$];
    logic [7:0] x;
    int         n;
    gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 12;
    fb = {SyncWord[31:24], SyncWord[23:16], SyncWord[15:8], SyncWord[7:0]};
    repeat (4) fb.push_back(8'($urandom));
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    if (len >= 3 && len <= MaxLengthDefault) begin
      fb.push_back(cmd);
      fb.push_back(code[15:8]);
      fb.push_back(code[7:0]);
      repeat (len - 3) fb.push_back(8'($urandom));
      x = 8'h00;
      for (int i = 4; i < fb.size(); i++) x ^= fb[i];
      fb.push_back(bad_xor ? x ^ 8'($urandom_range(1, 255)) : x);
    end
    n = (cut >= 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) send_byte(fb[i], 1'b0);
  endtask

  task automatic send_random_frame(input int cut);
    int          r;
    logic [15:0] len;
    r = $urandom_range(0, 19);
    if (r == 0) len = 16'($urandom_range(3, MaxLengthDefault));
    else if (r == 1) len = 16'(MaxLengthDefault);
    else if (r == 2) len = 16'd3;
    else len = 16'($urandom_range(3, 14));
    send_frame(len, ($urandom_range(0, 4) != 0) ? cur_cmd : 8'($urandom),
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000,
               $urandom_range(0, 9) == 0, cut);
  endtask

  task automatic random_phase(input int n);
    int          start;
    int          k;
    logic [15:0] len;
    start = items_sent;
    while (items_sent - start < n) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        send_random_frame(-1);
      end else if (k < 65) begin
        case ($urandom_range(0, 4))
          0:       len = 16'd246;
          1:       len = 16'hFFFF;
          2:       len = 16'($urandom_range(246, 65535));
          default: len = 16'($urandom_range(0, 2));
        endcase
        send_frame(len, cur_cmd, 16'h0000, 1'b0, -1);
      end else if (k < 75) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        if ($urandom_range(0, 2) == 0) send_byte(8'($urandom), 1'b1);
      end else if (k < 88) begin
        send_random_frame($urandom_range(1, 24));
        send_byte(8'($urandom), 1'b1);
      end else begin
        // broken sync: partial pattern, then an arbitrary byte
        send_random_frame($urandom_range(1, 3));
        send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic settle(input int tail);
    rx_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_command(input logic [7:0] v);
    cfg_if.valid            <= 1'b1;
    cfg_if.expected_command <= v;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.set_command(v);
    cur_cmd = v;
    settings_used++;
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk                     = 1'b0;
    rst                     <= 1'b1;
    cfg_if.valid            <= 1'b0;
    cfg_if.expected_command <= 8'h00;
    rx_if.valid             <= 1'b0;
    rx_if.rx_byte           <= 8'h00;
    rx_if.abort             <= 1'b0;
    reply_if.ready          <= 1'b0;
    idle_on       = 1'b1;
    hold_request  = 1'b0;
    gap_pct       = 10;
    items_sent    = 0;
    settings_used = 0;
    cur_cmd       = CmdResetValue;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: noise extremes, shortest good frame, oversize length, idle abort
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_frame(16'd3, CmdResetValue, 16'h0000, 1'b0, -1);
    send_frame(16'hFFFF, CmdResetValue, 16'h0000, 1'b0, -1);
    send_byte(8'h5A, 1'b1);
    settle(3);

    write_command(8'hFF);
    random_phase(PhaseSize);
    settle(3);

    write_command(8'h00);
    hold_request = 1'b1;
    send_frame(16'd40, cur_cmd, 16'h0000, 1'b0, -1);
    random_phase(PhaseSize);
    settle(3);

    write_command(8'($urandom));
    random_phase(PhaseSize);
    settle(3);

    write_command(8'($urandom));
    idle_on = 1'b0;
    random_phase(PhaseSize - 50);
    settle(10);

    $display("run covered %0d received bytes, %0d command settings, %0d data transactions",
             items_sent, settings_used, tracker.data_seen);
    $display("status counts: ok %0d sync %0d long %0d short %0d xor %0d cmd %0d dev %0d",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_BAD_SYNC],
             tracker.status_seen[ST_TOO_LONG], tracker.status_seen[ST_TOO_SHORT],
             tracker.status_seen[ST_XOR_ERR], tracker.status_seen[ST_CMD_MISMATCH],
             tracker.status_seen[ST_DEVICE_ERR]);
    if (tracker.mismatches == 0) begin
      $display("[serial_reply_frame_checker_unit] OK");
    end else begin
      $display("[serial_reply_frame_checker_unit] ERROR");
    end
    $finish;
  end

endmodule
